### hw/rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg: shared types and constants of the critically damped smoother
// Q16.16 field widths, coefficient constants, register codes and the
// saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int unsigned Q_W   = 32;    // signed Q16.16 positions and velocity
    localparam int unsigned DT_W  = 17;    // unsigned Q1.16 time step
    localparam int unsigned CFG_W = 31;    // configuration register width

    // Intermediate values are clipped to +-(2^47 - 1)
    localparam logic [46:0] WIDE_MAX = 47'h7FFF_FFFF_FFFF;

    localparam logic [30:0] MIN_SMOOTH      = 31'd7;          // 0.0001 s
    localparam logic [30:0] SMOOTH_TIME_RST = 31'd19661;      // 0.3 s
    localparam logic [30:0] MAX_SPEED_RST   = 31'h7FFF_FFFF;

    localparam logic [31:0] C_048  = 32'd31457;    // 0.48
    localparam logic [31:0] C_0235 = 32'd15401;    // 0.235
    localparam logic [24:0] X_CAP  = 25'h100_0000; // 256.0

    typedef enum logic [0:0] {
        CFG_SMOOTH_TIME = 1'b0,
        CFG_MAX_SPEED   = 1'b1
    } t_cfg_reg;

    function automatic logic signed [47:0] sat_wide(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = $signed({3'b000, WIDE_MAX});
        lo = -hi;
        if (v > hi) begin
            return hi[47:0];
        end else if (v < lo) begin
            return lo[47:0];
        end
        return v[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < 48'shFFFF_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

### hw/rtl/cds_in_if.sv
// ----------------------------------------------------------------------------
// cds_in_if: input item channel of the smoother
// Valid/ready handshake carrying position, target and time step.
// ----------------------------------------------------------------------------
interface cds_in_if;

    logic                              valid;
    logic                              ready;
    logic signed [cds_pkg::Q_W-1:0]    current_value;
    logic signed [cds_pkg::Q_W-1:0]    target_value;
    logic        [cds_pkg::DT_W-1:0]   time_step;

    modport source (
        output valid, current_value, target_value, time_step,
        input  ready
    );

    modport sink (
        input  valid, current_value, target_value, time_step,
        output ready
    );

endinterface

### hw/rtl/cds_out_if.sv
// ----------------------------------------------------------------------------
// cds_out_if: result item channel of the smoother
// Valid/ready handshake carrying the new position and velocity.
// ----------------------------------------------------------------------------
interface cds_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [cds_pkg::Q_W-1:0]    new_value;
    logic signed [cds_pkg::Q_W-1:0]    new_velocity;

    modport source (
        output valid, new_value, new_velocity,
        input  ready
    );

    modport sink (
        input  valid, new_value, new_velocity,
        output ready
    );

endinterface

### hw/rtl/critically_damped_smoother.sv
// ----------------------------------------------------------------------------
// critically_damped_smoother: critically damped spring smoothing in Q16.16
// Moves a position toward a target with a stored velocity, using one shared
// 48x16 multiply-accumulate unit and one bit-serial divider under a sequencer.
// ----------------------------------------------------------------------------
// Usage
//   i_in carries one item: current_value, target_value, time_step. It is
//   taken when valid and ready are high at a clock edge; ready is high only
//   while the sequencer is idle, one item at a time.
//   o_out carries one result per item: new_value and new_velocity, held in
//   an output register until the receiver takes it. The next item is taken
//   while that result still waits.
//   Each item takes ten products and a 17-step division for the decay
//   factor; a new item is taken only once the last one has left the
//   sequencer. The first item after a write to either register also
//   forms 2/smooth_time (31 divider steps) and the error limit.
//   A stalled receiver holds the finished result in the output register;
//   the sequencer then waits before writing the next one.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 smooth_time, 1 max_speed); the user must write only while idle, the block does not enforce it.
//   Reset: velocity cleared, registers to 0.3 s and the maximum speed.
// ----------------------------------------------------------------------------
module critically_damped_smoother (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  cds_pkg::t_cfg_reg                i_cfg_index,
    input  logic [cds_pkg::CFG_W-1:0]        i_cfg_data,
    cds_in_if.sink                           i_in,
    cds_out_if.source                        o_out
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OMEGA,
        S_LIM,
        S_X,
        S_X2,
        S_X3,
        S_C1,
        S_C2,
        S_DECAY,
        S_T1,
        S_T7,
        S_V1,
        S_V2,
        S_RES,
        S_DONE
    } t_state;

    localparam logic [40:0] OMEGA_REM_INIT = 41'd4;       // 2^33 >> 31
    localparam logic [4:0]  OMEGA_STEPS    = 5'd31;
    localparam logic [40:0] DECAY_REM_INIT = 41'h8000;    // 2^32 >> 17
    localparam logic [4:0]  DECAY_STEPS    = 5'd17;
    localparam logic [40:0] DEN_ONE        = 41'h1_0000;

    // control
    t_state                 r_state;
    t_state                 r_ret;
    logic                   r_coef_ok;
    logic                   r_out_valid;
    logic [30:0]            r_smooth_time;
    logic [30:0]            r_max_speed;
    logic signed [31:0]     r_vel;

    // item and intermediates
    logic signed [31:0]     r_cur;
    logic signed [31:0]     r_tgt;
    logic [16:0]            r_dt;
    logic [30:0]            r_omega;
    logic [46:0]            r_lim;
    logic [24:0]            r_x;
    logic [32:0]            r_x2;
    logic [40:0]            r_x3;
    logic [40:0]            r_den;
    logic [16:0]            r_decay;
    logic signed [33:0]     r_err;
    logic signed [47:0]     r_t7;
    logic signed [47:0]     r_vnew;
    logic signed [31:0]     r_res;
    logic signed [31:0]     r_new_value;
    logic signed [31:0]     r_new_velocity;

    // shared multiplier
    logic [47:0]            r_ma;
    logic [31:0]            r_mb;
    logic [79:0]            r_acc;
    logic                   r_mdig;
    logic                   r_mneg;

    // shared divider
    logic [40:0]            r_rem;
    logic [40:0]            r_dvs;
    logic [30:0]            r_q;
    logic [4:0]             r_dcnt;

    logic                   in_fire;
    logic [30:0]            st_eff;

    logic [15:0]            mul_digit;
    logic [63:0]            mul_pp;
    logic [79:0]            n_acc;
    logic [63:0]            prod_hi;
    logic [46:0]            prod_mag;
    logic signed [47:0]     prod_s;
    logic [24:0]            x_c;
    logic [40:0]            den_c;

    logic [41:0]            rem_sh;
    logic [41:0]            div_diff;
    logic                   div_ge;
    logic [40:0]            n_rem;

    logic signed [32:0]     diff;
    logic signed [47:0]     diff48;
    logic signed [47:0]     lim_s;
    logic signed [33:0]     err_c;
    logic [47:0]            err_mag;
    logic signed [34:0]     base;

    logic signed [49:0]     add_a;
    logic signed [49:0]     add_b;
    logic signed [49:0]     sum_w;
    logic signed [47:0]     sum_sat;
    logic [47:0]            sum_mag;
    logic                   overshoot;

    logic                   mul_go;
    logic [47:0]            mul_a;
    logic [31:0]            mul_b;
    logic                   mul_neg;
    t_state                 mul_ret;

    logic                   div_go;
    logic [40:0]            div_rem;
    logic [40:0]            div_dvs;
    logic [4:0]             div_steps;
    t_state                 div_ret;

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid        = r_out_valid;
    assign o_out.new_value    = r_new_value;
    assign o_out.new_velocity = r_new_velocity;

    assign st_eff = (r_smooth_time < cds_pkg::MIN_SMOOTH) ? cds_pkg::MIN_SMOOTH
                                                            : r_smooth_time;

    // one 16-bit digit of the second operand per cycle, low digit first
    assign mul_digit = r_mdig ? r_mb[31:16] : r_mb[15:0];
    assign mul_pp    = r_ma * mul_digit;
    assign n_acc     = r_mdig ? (r_acc + {mul_pp, 16'd0}) : {16'd0, mul_pp};

    assign prod_hi  = r_acc[79:16];
    assign prod_mag = (prod_hi > {17'd0, cds_pkg::WIDE_MAX}) ? cds_pkg::WIDE_MAX
                                                             : prod_hi[46:0];
    assign prod_s   = r_mneg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
    assign x_c      = (prod_hi > {39'd0, cds_pkg::X_CAP}) ? cds_pkg::X_CAP : prod_hi[24:0];
    assign den_c    = r_den + prod_hi[40:0];

    // restoring divider step, shifting in zero dividend bits
    assign rem_sh   = {r_rem, 1'b0};
    assign div_diff = rem_sh - {1'b0, r_dvs};
    assign div_ge   = (rem_sh >= {1'b0, r_dvs});
    assign n_rem    = div_ge ? div_diff[40:0] : rem_sh[40:0];

    // position error, clamped to the error limit (max_speed times smooth_time)
    assign diff   = $signed({r_cur[31], r_cur}) - $signed({r_tgt[31], r_tgt});
    assign diff48 = $signed({{15{diff[32]}}, diff});
    assign lim_s  = $signed({1'b0, r_lim});

    always_comb begin
        if (diff48 > lim_s) begin
            err_c = $signed({1'b0, r_lim[32:0]});
        end else if (diff48 < -lim_s) begin
            err_c = -$signed({1'b0, r_lim[32:0]});
        end else begin
            err_c = $signed({diff[32], diff});
        end
    end

    assign err_mag = {14'd0, (err_c[33] ? $unsigned(-err_c) : $unsigned(err_c))};
    assign base    = $signed({{3{r_cur[31]}}, r_cur}) - $signed({r_err[33], r_err});

    // shared wide adder
    always_comb begin
        add_a = '0;
        add_b = '0;
        case (r_state)
            S_T1: begin
                add_a = $signed({{18{r_vel[31]}}, r_vel});
                add_b = $signed({{2{prod_s[47]}}, prod_s});
            end
            S_V1: begin
                add_a = $signed({{18{r_vel[31]}}, r_vel});
                add_b = -$signed({{2{prod_s[47]}}, prod_s});
            end
            S_V2: begin
                add_a = $signed({{16{r_err[33]}}, r_err});
                add_b = $signed({{2{r_t7[47]}}, r_t7});
            end
            S_RES: begin
                add_a = $signed({{15{base[34]}}, base});
                add_b = $signed({{2{prod_s[47]}}, prod_s});
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign sum_w     = add_a + add_b;
    assign sum_sat   = cds_pkg::sat_wide(sum_w);
    assign sum_mag   = sum_sat[47] ? $unsigned(-sum_sat) : $unsigned(sum_sat);
    assign overshoot = ((r_tgt > r_cur) == (sum_sat > $signed({{16{r_tgt[31]}}, r_tgt})));

    // operands for the next product
    always_comb begin
        mul_go  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_ret = S_IDLE;
        case (r_state)
            S_IDLE: begin
                if (in_fire && r_coef_ok) begin
                    mul_go  = 1'b1;
                    mul_a   = {17'd0, r_omega};
                    mul_b   = {15'd0, i_in.time_step};
                    mul_ret = S_X;
                end
            end
            S_OMEGA: begin
                mul_go  = 1'b1;
                mul_a   = {17'd0, st_eff};
                mul_b   = {1'b0, r_max_speed};
                mul_ret = S_LIM;
            end
            S_LIM: begin
                mul_go  = 1'b1;
                mul_a   = {17'd0, r_omega};
                mul_b   = {15'd0, r_dt};
                mul_ret = S_X;
            end
            S_X: begin
                mul_go  = 1'b1;
                mul_a   = {23'd0, x_c};
                mul_b   = {7'd0, x_c};
                mul_ret = S_X2;
            end
            S_X2: begin
                mul_go  = 1'b1;
                mul_a   = {15'd0, prod_hi[32:0]};
                mul_b   = {7'd0, r_x};
                mul_ret = S_X3;
            end
            S_X3: begin
                mul_go  = 1'b1;
                mul_a   = {15'd0, r_x2};
                mul_b   = cds_pkg::C_048;
                mul_ret = S_C1;
            end
            S_C1: begin
                mul_go  = 1'b1;
                mul_a   = {7'd0, r_x3};
                mul_b   = cds_pkg::C_0235;
                mul_ret = S_C2;
            end
            S_DECAY: begin
                mul_go  = 1'b1;
                mul_a   = err_mag;
                mul_b   = {1'b0, r_omega};
                mul_neg = err_c[33];
                mul_ret = S_T1;
            end
            S_T1: begin
                mul_go  = 1'b1;
                mul_a   = sum_mag;
                mul_b   = {15'd0, r_dt};
                mul_neg = sum_sat[47];
                mul_ret = S_T7;
            end
            S_T7: begin
                mul_go  = 1'b1;
                mul_a   = {1'b0, prod_mag};
                mul_b   = {1'b0, r_omega};
                mul_neg = r_mneg;
                mul_ret = S_V1;
            end
            S_V1: begin
                mul_go  = 1'b1;
                mul_a   = sum_mag;
                mul_b   = {15'd0, r_decay};
                mul_neg = sum_sat[47];
                mul_ret = S_V2;
            end
            S_V2: begin
                mul_go  = 1'b1;
                mul_a   = sum_mag;
                mul_b   = {15'd0, r_decay};
                mul_neg = sum_sat[47];
                mul_ret = S_RES;
            end
            default: begin
                mul_go = 1'b0;
            end
        endcase
    end

    // divisions: 2/smooth_time and the decay factor
    always_comb begin
        div_go    = 1'b0;
        div_rem   = '0;
        div_dvs   = '0;
        div_steps = '0;
        div_ret   = S_IDLE;
        case (r_state)
            S_IDLE: begin
                if (in_fire && !r_coef_ok) begin
                    div_go    = 1'b1;
                    div_rem   = OMEGA_REM_INIT;
                    div_dvs   = {10'd0, st_eff};
                    div_steps = OMEGA_STEPS;
                    div_ret   = S_OMEGA;
                end
            end
            S_C2: begin
                div_go    = 1'b1;
                div_rem   = DECAY_REM_INIT;
                div_dvs   = den_c;
                div_steps = DECAY_STEPS;
                div_ret   = S_DECAY;
            end
            default: begin
                div_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ret         <= S_IDLE;
            r_coef_ok     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_vel         <= '0;
            r_smooth_time <= cds_pkg::SMOOTH_TIME_RST;
            r_max_speed   <= cds_pkg::MAX_SPEED_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cds_pkg::CFG_SMOOTH_TIME: r_smooth_time <= i_cfg_data;
                    cds_pkg::CFG_MAX_SPEED:   r_max_speed   <= i_cfg_data;
                    default:                  r_max_speed   <= r_max_speed;
                endcase
                // drop the cached omega and limit
                r_coef_ok <= 1'b0;
            end

            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (mul_go) begin
                r_ma   <= mul_a;
                r_mb   <= mul_b;
                r_mneg <= mul_neg;
                r_mdig <= 1'b0;
                r_ret  <= mul_ret;
            end

            if (div_go) begin
                r_rem  <= div_rem;
                r_dvs  <= div_dvs;
                r_dcnt <= div_steps;
                r_q    <= '0;
                r_ret  <= div_ret;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cur   <= i_in.current_value;
                        r_tgt   <= i_in.target_value;
                        r_dt    <= i_in.time_step;
                        r_state <= r_coef_ok ? S_MUL : S_DIV;
                    end
                end
                S_MUL: begin
                    r_acc  <= n_acc;
                    r_mdig <= 1'b1;
                    if (r_mdig) begin
                        r_state <= r_ret;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_q    <= {r_q[29:0], div_ge};
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd1) begin
                        r_state <= r_ret;
                    end
                end
                S_OMEGA: begin
                    r_omega <= r_q;
                    r_state <= S_MUL;
                end
                S_LIM: begin
                    r_lim     <= prod_hi[46:0];
                    r_coef_ok <= 1'b1;
                    r_state   <= S_MUL;
                end
                S_X: begin
                    r_x     <= x_c;
                    r_state <= S_MUL;
                end
                S_X2: begin
                    r_x2    <= prod_hi[32:0];
                    r_state <= S_MUL;
                end
                S_X3: begin
                    r_x3    <= prod_hi[40:0];
                    r_state <= S_MUL;
                end
                S_C1: begin
                    r_den   <= DEN_ONE + {16'd0, r_x} + {9'd0, prod_hi[31:0]};
                    r_state <= S_MUL;
                end
                S_C2: begin
                    r_state <= S_DIV;
                end
                S_DECAY: begin
                    r_decay <= r_q[16:0];
                    r_err   <= err_c;
                    r_state <= S_MUL;
                end
                S_T1: begin
                    r_state <= S_MUL;
                end
                S_T7: begin
                    r_t7    <= prod_s;
                    r_state <= S_MUL;
                end
                S_V1: begin
                    r_state <= S_MUL;
                end
                S_V2: begin
                    r_vnew  <= prod_s;
                    r_state <= S_MUL;
                end
                S_RES: begin
                    // past the target: land on it and stop
                    if (overshoot) begin
                        r_res <= r_tgt;
                        r_vel <= '0;
                    end else begin
                        r_res <= cds_pkg::sat32(sum_sat);
                        r_vel <= cds_pkg::sat32(r_vnew);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_new_value    <= r_res;
                        r_new_velocity <= r_vel;
                        r_out_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in.ready)
        else $error("input taken while an item is in progress");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dvs))
        else $error("divider partial remainder not below divisor");

    a_decay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T1) |-> (r_decay <= 17'h1_0000))
        else $error("decay factor above one");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the completion step");

    a_coef_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_X) |-> r_coef_ok)
        else $error("step product formed with stale omega or limit");
`endif

endmodule

### verif/critically_damped_smoother_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// critically_damped_smoother_tb: self-checking bench for the smoother
// Drives position/target/time-step items under random bursts and stalls.
// It predicts each new position and velocity with its own Q16.16 smooth-damp
// step and checks every result item in order. The bench covers directed
// corner cases, register corners, a long receiver hold-off and random
// tracking runs mixed with noise.
// ----------------------------------------------------------------------------
module critically_damped_smoother_tb;

    import cds_pkg::*;

    localparam int              RST_CYCLES      = 3;
    localparam int              SETTLE_CYCLES   = 100;  // latency plus the register reload
    localparam int              HOLD_OFF_CYCLES = 400;
    localparam int              RUN_LIMIT_NS    = 20_000_000;

    localparam logic signed [31:0] Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE    = 32'sd65536;
    localparam logic [16:0]        ONE_SEC  = 17'd65536;
    localparam logic [16:0]        DT_MAX   = 17'h1_FFFF;
    localparam logic [16:0]        FRAME_DT = 17'd1092;    // about 1/60 s

    localparam longint          CLIP_LIM = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint unsigned ST_FLOOR = 7;
    localparam longint unsigned K_048    = 31457;
    localparam longint unsigned K_0235   = 15401;
    localparam longint unsigned X_LIMIT  = 64'd1 << 24;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
    } move_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    t_cfg_reg  cfg_index;
    logic [30:0] cfg_data;

    cds_in_if  in_ch ();
    cds_out_if out_ch ();

    critically_damped_smoother u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #5 clk = ~clk;

    // predictor state and configuration
    logic [30:0]        smooth_time_cfg = SMOOTH_TIME_RST;
    logic [30:0]        max_speed_cfg   = MAX_SPEED_RST;
    logic signed [31:0] velocity_state  = '0;
    logic signed [31:0] last_position   = '0;

    move_t expected_moves[$];
    int    error_count   = 0;

    // sender and receiver pacing
    int    gap_max       = 0;
    int    burst_left    = 0;
    bit    rx_stalls     = 1'b0;
    int    hold_off_req  = 0;
    int    hold_off_left = 0;
    logic [31:0] stall_word = '1;
    logic [4:0]  stall_bit  = '0;

    function automatic longint clip_wide(input longint v);
        if (v > CLIP_LIM) begin
            return CLIP_LIM;
        end else if (v < -CLIP_LIM) begin
            return -CLIP_LIM;
        end
        return v;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > longint'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < longint'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // Q16.16 product, truncated toward zero and clipped to the wide range
    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] mag_a;
        logic [127:0] mag_b;
        logic [127:0] prod;
        longint       r;
        mag_a = (a < 0) ? -a : a;
        mag_b = (b < 0) ? -b : b;
        prod  = (mag_a * mag_b) >> 16;
        if (prod > CLIP_LIM) begin
            prod = CLIP_LIM;
        end
        r = longint'(prod[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // One smooth-damp update; advances the stored velocity
    function automatic move_t smooth_damp_step(input logic signed [31:0] cur_in,
                                               input logic signed [31:0] goal_in,
                                               input logic [16:0]        step_in);
        longint unsigned st;
        longint unsigned omega_u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned x3;
        longint unsigned den;
        longint          omega;
        longint          decay;
        longint          lim;
        longint          cur;
        longint          goal;
        longint          dt;
        longint          err;
        longint          base;
        longint          drift;
        longint          vnew;
        longint          pos;
        move_t           res;
        st      = (smooth_time_cfg < ST_FLOOR) ? ST_FLOOR : smooth_time_cfg;
        omega_u = (64'd1 << 33) / st;
        x       = (omega_u * step_in) >> 16;
        if (x > X_LIMIT) begin
            x = X_LIMIT;
        end
        x2    = (x * x) >> 16;
        x3    = (x2 * x) >> 16;
        den   = 64'd65536 + x + ((K_048 * x2) >> 16) + ((K_0235 * x3) >> 16);
        decay = longint'((64'd1 << 32) / den);
        lim   = longint'((max_speed_cfg * st) >> 16);
        omega = longint'(omega_u);
        cur   = cur_in;
        goal  = goal_in;
        dt    = step_in;

        err = cur - goal;
        if (err > lim) begin
            err = lim;
        end else if (err < -lim) begin
            err = -lim;
        end
        base  = cur - err;
        drift = q_mul(clip_wide(velocity_state + q_mul(omega, err)), dt);
        vnew  = q_mul(clip_wide(velocity_state - q_mul(omega, drift)), decay);
        pos   = clip_wide(base + q_mul(clip_wide(err + drift), decay));

        // snap to the target when the step would carry past it
        if ((goal - cur > 0) == (pos > goal)) begin
            pos  = goal;
            vnew = 0;
        end
        res.position   = clip32(pos);
        res.velocity   = clip32(vnew);
        velocity_state = res.velocity;
        last_position  = res.position;
        return res;
    endfunction

    // Offer one item; record its expected move once taken
    task automatic offer_item(input logic signed [31:0] cur,
                              input logic signed [31:0] goal,
                              input logic [16:0]        step);
        @(negedge clk);
        if (gap_max != 0) begin
            if (burst_left == 0) begin
                in_ch.valid = 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge clk);
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        in_ch.current_value = cur;
        in_ch.target_value  = goal;
        in_ch.time_step     = step;
        in_ch.valid         = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        expected_moves.push_back(smooth_damp_step(cur, goal, step));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_moves.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg which, input logic [30:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = which;
        cfg_data  = value;
        case (which)
            CFG_SMOOTH_TIME: smooth_time_cfg = value;
            CFG_MAX_SPEED:   max_speed_cfg   = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [31:0] rand_near(input int unsigned span);
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    // Receiver: long hold-off on request, otherwise a rolling stall word
    always @(negedge clk) begin
        if (hold_off_req != 0) begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            out_ch.ready = 1'b0;
        end else begin
            if (stall_bit == '0) begin
                case ($urandom_range(0, 3))
                    0:       stall_word = '1;
                    1:       stall_word = $urandom & $urandom;
                    default: stall_word = $urandom | $urandom;
                endcase
            end
            out_ch.ready = rx_stalls ? stall_word[stall_bit] : 1'b1;
            stall_bit++;
        end
    end

    always @(posedge clk) begin
        move_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_moves.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual %h %h",
                         $time, out_ch.new_value, out_ch.new_velocity);
                error_count++;
            end else begin
                want = expected_moves.pop_front();
                if (out_ch.new_value !== want.position) begin
                    $display("%0t: new_value expected %h actual %h",
                             $time, want.position, out_ch.new_value);
                    error_count++;
                end
                if (out_ch.new_velocity !== want.velocity) begin
                    $display("%0t: new_velocity expected %h actual %h",
                             $time, want.velocity, out_ch.new_velocity);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed_extremes();
        gap_max   = 6;
        rx_stalls = 1'b1;
        offer_item(32'sd0, 32'sd0, FRAME_DT);               // already at the target
        offer_item(Q_MIN, Q_MAX, ONE_SEC);
        offer_item(Q_MAX, Q_MIN, ONE_SEC);
        offer_item(Q_MIN, Q_MAX, 17'd0);                    // zero time step
        offer_item(100 * Q_ONE, 32'sd0, DT_MAX);            // step beyond one second
        offer_item(-5 * Q_ONE, 5 * Q_ONE, 17'd1);
        offer_item(last_position, 5 * Q_ONE, FRAME_DT);
        offer_item(5 * Q_ONE, 5 * Q_ONE + 1, FRAME_DT);
    endtask

    task automatic test_register_corners();
        write_reg(CFG_SMOOTH_TIME, 31'd0);                  // raised to the floor
        offer_item(Q_MIN, Q_MAX, 17'd1);
        offer_item(last_position, Q_MAX, 17'd1);
        offer_item(32'sd0, -Q_ONE, FRAME_DT);
        write_reg(CFG_SMOOTH_TIME, 31'd7);
        offer_item(3 * Q_ONE, 32'sd0, 17'd3);
        offer_item(last_position, 32'sd0, 17'd3);
        write_reg(CFG_SMOOTH_TIME, 31'h7FFF_FFFF);
        write_reg(CFG_MAX_SPEED, 31'd0);                    // error held at zero
        offer_item(Q_MAX, Q_MIN, ONE_SEC);
        offer_item(-100 * Q_ONE, 100 * Q_ONE, FRAME_DT);
        write_reg(CFG_MAX_SPEED, 31'd1);
        offer_item(Q_MIN, Q_MAX, DT_MAX);
        offer_item(last_position, Q_MAX, DT_MAX);
        write_reg(CFG_SMOOTH_TIME, SMOOTH_TIME_RST);
        write_reg(CFG_MAX_SPEED, MAX_SPEED_RST);
    endtask

    // Stall the receiver while items keep coming so the input backs up
    task automatic test_fill_under_hold_off();
        logic signed [31:0] goal;
        drain_results();
        gap_max = 0;
        goal    = rand_near(200 * 65536);
        @(posedge clk);
        hold_off_req = HOLD_OFF_CYCLES;
        for (int k = 0; k < 14; k++) begin
            offer_item(last_position, goal, FRAME_DT);
        end
        drain_results();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        int                 sent;
        int                 run_len;
        logic signed [31:0] goal;
        logic signed [31:0] start;
        logic [16:0]        step;
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_SMOOTH_TIME, $urandom_range(0, 6));
                1:       write_reg(CFG_SMOOTH_TIME, 31'h7FFF_FFFF);
                2:       write_reg(CFG_SMOOTH_TIME, $urandom);
                default: write_reg(CFG_SMOOTH_TIME, $urandom_range(1000, 200000));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(CFG_MAX_SPEED, 31'd0);
                1:       write_reg(CFG_MAX_SPEED, 31'h7FFF_FFFF);
                2:       write_reg(CFG_MAX_SPEED, $urandom);
                default: write_reg(CFG_MAX_SPEED, $urandom_range(65536, 100 * 65536));
            endcase
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 10;
                default: gap_max = 90;
            endcase
            rx_stalls = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < per_phase) begin
                if ($urandom_range(0, 9) < 7) begin
                    // tracking run: feed each new position back as the next start
                    run_len = $urandom_range(4, 40);
                    goal    = ($urandom_range(0, 3) == 0) ? $urandom
                                                          : rand_near(1000 * 65536);
                    start   = ($urandom_range(0, 1) == 0) ? last_position
                                                          : rand_near(1000 * 65536);
                    case ($urandom_range(0, 4))
                        0:       step = FRAME_DT;
                        1:       step = FRAME_DT / 2;
                        2:       step = FRAME_DT * 2;
                        3:       step = $urandom_range(0, ONE_SEC);
                        default: step = $urandom_range(0, DT_MAX);
                    endcase
                    offer_item(start, goal, step);
                    for (int k = 1; k < run_len; k++) begin
                        offer_item(last_position, goal, step);
                    end
                    sent += run_len;
                end else begin
                    offer_item($urandom, $urandom, $urandom_range(0, DT_MAX));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_SMOOTH_TIME;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.current_value = '0;
        in_ch.target_value  = '0;
        in_ch.time_step     = '0;
        out_ch.ready        = 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_extremes();
        test_register_corners();
        test_fill_under_hold_off();
        test_random_phases(9, 205);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_moves.size() != 0) begin
            $display("%0t: %0d result items never arrived", $time, expected_moves.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("critically_damped_smoother test passed");
        end else begin
            $display("critically_damped_smoother test failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached", $time);
        $display("critically_damped_smoother test failed");
        $finish;
    end

endmodule
